>>> design/spd_pkg.sv
// Shared types, sizes and helpers for the stroke point decimator.
// Depends on nothing; every other file of the block imports it.
`default_nettype none

package spd_pkg;

  // Coordinate width and the widths that follow from it.
  localparam int COORD_BITS = 16;
  localparam int DIFF_BITS  = COORD_BITS + 1;       // signed difference of two points
  localparam int LEN_BITS   = 2 * COORD_BITS + 1;   // sum of two squared magnitudes
  localparam int PROD_BITS  = 2 * LEN_BITS;         // product of two such sums

  // Stroke width register and the minimum spacing derived from it.
  localparam int WIDTH_BITS  = 8;
  localparam int SPACE_BITS  = 7;                   // floor(255 / 3) = 85
  localparam int SPACE_RECIP = 171;                 // 171 / 512 ~ 1 / 3
  localparam int SPACE_SHIFT = 9;
  localparam int WPROD_BITS  = 2 * WIDTH_BITS;
  localparam logic [WIDTH_BITS-1:0] WIDTH_RESET = WIDTH_BITS'(4);
  localparam logic [SPACE_BITS-1:0] SPACE_RESET =
    (WIDTH_RESET / 3 == 0) ? SPACE_BITS'(1) : SPACE_BITS'(WIDTH_RESET / 3);

  // Configuration register indexes.
  localparam int CFG_IDX_BITS = 1;
  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_SMOOTHING_ON = 1'b0,
    REG_STROKE_WIDTH = 1'b1
  } cfg_reg_e;

  typedef struct packed {
    logic signed [COORD_BITS-1:0] in_x;
    logic signed [COORD_BITS-1:0] in_y;
    logic                         stroke_last;
  } spd_in_t;

  typedef struct packed {
    logic signed [COORD_BITS-1:0] out_x;
    logic signed [COORD_BITS-1:0] out_y;
    logic                         point_valid;
    logic                         stroke_end;
    logic                         run_last;
  } spd_out_t;

  // a - b with one guard bit, two's complement.
  function automatic logic [DIFF_BITS-1:0] coord_diff(input logic [COORD_BITS-1:0] a,
                                                       input logic [COORD_BITS-1:0] b);
    return {a[COORD_BITS-1], a} - {b[COORD_BITS-1], b};
  endfunction

  // Magnitude of a difference; never exceeds 2^COORD_BITS - 1.
  function automatic logic [COORD_BITS-1:0] diff_mag(input logic [DIFF_BITS-1:0] d);
    logic [DIFF_BITS-1:0] n;
    n = -d;
    return d[DIFF_BITS-1] ? n[COORD_BITS-1:0] : d[COORD_BITS-1:0];
  endfunction

endpackage

`default_nettype wire

>>> design/stroke_point_decimator.sv
// Stroke point decimator: top level with sequencer, state and output register.
// Depends on spd_pkg and spd_mul.
`default_nettype none

// Thins the raw points of a pen stroke, one point per input beat, with the
// stroke closed by stroke_last. With smoothing off (sampled at a stroke's first
// point) or for strokes of one or two raw points every point passes through.
// Otherwise consecutive duplicates are dropped, the first point is kept, and an
// interior point is kept when it is a corner (dot <= 0 or 4*dot^2 <=
// |in|^2*|out|^2, exact) or lies at least max(1, stroke_width/3) from the last
// kept point. The last point is kept if it differs from the last kept point,
// otherwise an end marker (point_valid = 0, stroke_end = 1) closes the stroke.
// An input beat may cause zero, one or two result beats; run_last flags the
// last one. A new point is accepted only once the block is back in idle. An
// interior point that must be judged goes through the one shared 33x33
// multiplier, which forms eleven products in turn (dot terms, both vector
// lengths, the distance, the spacing square, dot^2 and the length product),
// one per cycle, followed by a drain step. Emitting waits only while the
// output register still holds an untaken beat. Configuration is always ready
// and is to be written only while the block is idle.

module stroke_point_decimator (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  // point input
  input  wire logic                             in_valid_i,
  output logic                                  in_ready_o,
  input  wire spd_pkg::spd_in_t                 in_i,
  // result output
  output logic                                  out_valid_o,
  input  wire logic                             out_ready_i,
  output spd_pkg::spd_out_t                     out_o,
  // configuration writes
  input  wire logic                             cfg_valid_i,
  output logic                                  cfg_ready_o,
  input  wire logic [spd_pkg::CFG_IDX_BITS-1:0] cfg_index_i,
  input  wire logic [spd_pkg::WIDTH_BITS-1:0]   cfg_data_i
);
  import spd_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECIDE,
    S_MUL,
    S_JUDGE,
    S_FINAL
  } state_e;

  // Multiplier schedule; the product of a step is folded in on the next one.
  typedef enum logic [3:0] {
    ST_IXOX,
    ST_IYOY,
    ST_IXIX,
    ST_IYIY,
    ST_OXOX,
    ST_OYOY,
    ST_DXDX,
    ST_DYDY,
    ST_SPSP,
    ST_DD,
    ST_LL,
    ST_DRAIN
  } step_e;

  state_e state_q;
  step_e  step_q;

  // configuration
  logic                  smooth_on_q;
  logic [SPACE_BITS-1:0] space_q;
  logic [SPACE_BITS-1:0] space_d;
  logic [WPROD_BITS-1:0] wprod;
  logic [SPACE_BITS-1:0] space_raw;

  // stroke state
  logic                  stroke_smooth_q;
  logic [1:0]            raw_q;
  logic [1:0]            distinct_q;
  logic [COORD_BITS-1:0] kept_x_q, kept_y_q;
  logic [COORD_BITS-1:0] pend_x_q, pend_y_q;
  logic [COORD_BITS-1:0] bef_x_q, bef_y_q;
  logic [COORD_BITS-1:0] cur_x_q, cur_y_q;
  logic                  cur_last_q;

  // arithmetic accumulators
  logic signed [LEN_BITS:0] dot_q;
  logic [LEN_BITS-1:0]      l1_q, l2_q, dist_q;
  logic [2*SPACE_BITS-1:0]  spsq_q;
  logic [PROD_BITS-1:0]     dd_q, ll_q;

  // output register
  logic     out_valid_q;
  spd_out_t out_q;
  logic     out_free;
  logic     pass_pt;
  logic     out_load;

  // shared multiplier
  logic                 mul_en;
  logic [LEN_BITS-1:0]  op_a, op_b;
  logic [PROD_BITS-1:0] prod;
  logic [LEN_BITS:0]    prod_ext;

  // vectors around the pending point
  logic [DIFF_BITS-1:0]  ix, iy, ox, oy, dx, dy;
  logic [COORD_BITS-1:0] ix_m, iy_m, ox_m, oy_m, dx_m, dy_m;
  logic                  sgn_x, sgn_y;
  logic                  cur_eq_pend, cur_eq_kept, pend_eq_kept;
  logic                  zero_vec, dot_le0, corner, far, keep, fresh, dist2;

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;
  assign out_free    = !out_valid_q || out_ready_i;

  // Point goes out as is: first point, unsmoothed stroke, or short stroke end.
  assign pass_pt  = (raw_q == 2'd0) || !stroke_smooth_q || ((raw_q == 2'd1) && cur_last_q);
  assign out_load = out_free && (((state_q == S_DECIDE) && pass_pt) ||
                                 ((state_q == S_JUDGE) && keep) ||
                                 (state_q == S_FINAL));

  // Spacing = floor(width / 3) by reciprocal multiply, floored at one.
  always_comb begin
    wprod     = WPROD_BITS'(cfg_data_i) * WPROD_BITS'(SPACE_RECIP);
    space_raw = wprod[SPACE_SHIFT +: SPACE_BITS];
    space_d   = (space_raw == '0) ? SPACE_BITS'(1) : space_raw;
  end

  assign ix = coord_diff(pend_x_q, bef_x_q);
  assign iy = coord_diff(pend_y_q, bef_y_q);
  assign ox = coord_diff(cur_x_q, pend_x_q);
  assign oy = coord_diff(cur_y_q, pend_y_q);
  assign dx = coord_diff(pend_x_q, kept_x_q);
  assign dy = coord_diff(pend_y_q, kept_y_q);

  assign ix_m = diff_mag(ix);
  assign iy_m = diff_mag(iy);
  assign ox_m = diff_mag(ox);
  assign oy_m = diff_mag(oy);
  assign dx_m = diff_mag(dx);
  assign dy_m = diff_mag(dy);

  assign sgn_x = ix[DIFF_BITS-1] ^ ox[DIFF_BITS-1];
  assign sgn_y = iy[DIFF_BITS-1] ^ oy[DIFF_BITS-1];

  assign cur_eq_pend  = (cur_x_q == pend_x_q) && (cur_y_q == pend_y_q);
  assign cur_eq_kept  = (cur_x_q == kept_x_q) && (cur_y_q == kept_y_q);
  assign pend_eq_kept = (pend_x_q == kept_x_q) && (pend_y_q == kept_y_q);
  assign dist2        = (distinct_q == 2'd2);
  assign fresh        = dist2 ? !cur_eq_pend : !cur_eq_kept;

  assign zero_vec = ((ix == '0) && (iy == '0)) || ((ox == '0) && (oy == '0));
  assign dot_le0  = dot_q[LEN_BITS] || (dot_q == '0);
  assign corner   = !zero_vec && (dot_le0 || ({dd_q, 2'b00} <= {2'b00, ll_q}));
  assign far      = (dist_q >= LEN_BITS'(spsq_q));
  assign keep     = corner || far;

  assign prod_ext = {1'b0, prod[LEN_BITS-1:0]};

  // Operand select for the shared multiplier.
  always_comb begin
    op_a = '0;
    op_b = '0;
    case (step_q)
      ST_IXOX: begin op_a = LEN_BITS'(ix_m); op_b = LEN_BITS'(ox_m); end
      ST_IYOY: begin op_a = LEN_BITS'(iy_m); op_b = LEN_BITS'(oy_m); end
      ST_IXIX: begin op_a = LEN_BITS'(ix_m); op_b = LEN_BITS'(ix_m); end
      ST_IYIY: begin op_a = LEN_BITS'(iy_m); op_b = LEN_BITS'(iy_m); end
      ST_OXOX: begin op_a = LEN_BITS'(ox_m); op_b = LEN_BITS'(ox_m); end
      ST_OYOY: begin op_a = LEN_BITS'(oy_m); op_b = LEN_BITS'(oy_m); end
      ST_DXDX: begin op_a = LEN_BITS'(dx_m); op_b = LEN_BITS'(dx_m); end
      ST_DYDY: begin op_a = LEN_BITS'(dy_m); op_b = LEN_BITS'(dy_m); end
      ST_SPSP: begin op_a = LEN_BITS'(space_q); op_b = LEN_BITS'(space_q); end
      // only a positive dot reaches the square compare
      ST_DD:   begin op_a = dot_q[LEN_BITS-1:0]; op_b = dot_q[LEN_BITS-1:0]; end
      ST_LL:   begin op_a = l1_q; op_b = l2_q; end
      default: begin op_a = '0; op_b = '0; end
    endcase
  end

  assign mul_en = (state_q == S_MUL) && (step_q != ST_DRAIN);

  spd_mul u_mul (
    .clk_i  (clk_i),
    .en_i   (mul_en),
    .op_a_i (op_a),
    .op_b_i (op_b),
    .prod_o (prod)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q         <= S_IDLE;
      step_q          <= ST_IXOX;
      smooth_on_q     <= 1'b1;
      space_q         <= SPACE_RESET;
      stroke_smooth_q <= 1'b0;
      raw_q           <= 2'd0;
      distinct_q      <= 2'd0;
      kept_x_q        <= '0;
      kept_y_q        <= '0;
      pend_x_q        <= '0;
      pend_y_q        <= '0;
      bef_x_q         <= '0;
      bef_y_q         <= '0;
      cur_x_q         <= '0;
      cur_y_q         <= '0;
      cur_last_q      <= 1'b0;
      dot_q           <= '0;
      l1_q            <= '0;
      l2_q            <= '0;
      dist_q          <= '0;
      spsq_q          <= '0;
      dd_q            <= '0;
      ll_q            <= '0;
      out_valid_q     <= 1'b0;
      out_q           <= '0;
    end else begin
      // Raise valid on a new beat; otherwise drop the beat once taken.
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end

      if (cfg_valid_i) begin
        case (cfg_reg_e'(cfg_index_i))
          REG_SMOOTHING_ON: smooth_on_q <= cfg_data_i[0];
          REG_STROKE_WIDTH: space_q     <= space_d;
          default: ;
        endcase
      end

      case (state_q)
        S_IDLE: begin
          if (in_valid_i) begin
            cur_x_q    <= in_i.in_x;
            cur_y_q    <= in_i.in_y;
            cur_last_q <= in_i.stroke_last;
            state_q    <= S_DECIDE;
          end
        end

        S_DECIDE: begin
          if (pass_pt) begin
            // Point goes out as is; hold until the output register frees.
            if (out_free) begin
              out_q.out_x       <= cur_x_q;
              out_q.out_y       <= cur_y_q;
              out_q.point_valid <= 1'b1;
              out_q.stroke_end  <= cur_last_q;
              out_q.run_last    <= 1'b1;
              if (raw_q == 2'd0) begin
                stroke_smooth_q <= smooth_on_q;
                kept_x_q        <= cur_x_q;
                kept_y_q        <= cur_y_q;
              end
              if (cur_last_q) begin
                raw_q      <= 2'd0;
                distinct_q <= 2'd0;
              end else if (raw_q == 2'd0) begin
                distinct_q <= 2'd1;
                raw_q      <= 2'd1;
              end else begin
                raw_q <= 2'd2;
              end
              state_q <= S_IDLE;
            end
          end else if (raw_q == 2'd1) begin
            // Second raw point: hold it until the stroke length is known.
            raw_q <= 2'd2;
            if (!cur_eq_kept) begin
              bef_x_q    <= kept_x_q;
              bef_y_q    <= kept_y_q;
              pend_x_q   <= cur_x_q;
              pend_y_q   <= cur_y_q;
              distinct_q <= 2'd2;
            end
            state_q <= S_IDLE;
          end else if (fresh && dist2) begin
            // New point settles the pending one: run the tests.
            step_q  <= ST_IXOX;
            state_q <= S_MUL;
          end else begin
            if (fresh) begin
              bef_x_q    <= kept_x_q;
              bef_y_q    <= kept_y_q;
              pend_x_q   <= cur_x_q;
              pend_y_q   <= cur_y_q;
              distinct_q <= 2'd2;
            end
            state_q <= cur_last_q ? S_FINAL : S_IDLE;
          end
        end

        S_MUL: begin
          // Fold in the product issued on the previous step.
          case (step_q)
            ST_IYOY: dot_q  <= sgn_x ? -$signed(prod_ext) : $signed(prod_ext);
            ST_IXIX: dot_q  <= sgn_y ? dot_q - $signed(prod_ext)
                                     : dot_q + $signed(prod_ext);
            ST_IYIY: l1_q   <= prod[LEN_BITS-1:0];
            ST_OXOX: l1_q   <= l1_q + prod[LEN_BITS-1:0];
            ST_OYOY: l2_q   <= prod[LEN_BITS-1:0];
            ST_DXDX: l2_q   <= l2_q + prod[LEN_BITS-1:0];
            ST_DYDY: dist_q <= prod[LEN_BITS-1:0];
            ST_SPSP: dist_q <= dist_q + prod[LEN_BITS-1:0];
            ST_DD:   spsq_q <= prod[2*SPACE_BITS-1:0];
            ST_LL:   dd_q   <= prod;
            ST_DRAIN: ll_q  <= prod;
            default: ;
          endcase
          if (step_q == ST_DRAIN) begin
            state_q <= S_JUDGE;
          end else begin
            step_q <= step_e'(4'(step_q) + 4'd1);
          end
        end

        S_JUDGE: begin
          if (!keep || out_free) begin
            if (keep) begin
              out_q.out_x       <= pend_x_q;
              out_q.out_y       <= pend_y_q;
              out_q.point_valid <= 1'b1;
              out_q.stroke_end  <= 1'b0;
              out_q.run_last    <= !cur_last_q;
              kept_x_q          <= pend_x_q;
              kept_y_q          <= pend_y_q;
            end
            // Advance the window by one distinct point.
            bef_x_q  <= pend_x_q;
            bef_y_q  <= pend_y_q;
            pend_x_q <= cur_x_q;
            pend_y_q <= cur_y_q;
            state_q  <= cur_last_q ? S_FINAL : S_IDLE;
          end
        end

        S_FINAL: begin
          if (out_free) begin
            out_q.stroke_end <= 1'b1;
            out_q.run_last   <= 1'b1;
            if (dist2 && !pend_eq_kept) begin
              out_q.out_x       <= pend_x_q;
              out_q.out_y       <= pend_y_q;
              out_q.point_valid <= 1'b1;
              kept_x_q          <= pend_x_q;
              kept_y_q          <= pend_y_q;
            end else begin
              out_q.out_x       <= '0;
              out_q.out_y       <= '0;
              out_q.point_valid <= 1'b0;
            end
            raw_q      <= 2'd0;
            distinct_q <= 2'd0;
            state_q    <= S_IDLE;
          end
        end

        default: state_q <= S_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

>>> design/spd_mul.sv
// Shared unsigned multiplier with a registered product.
// Depends on spd_pkg for operand and product widths.
`default_nettype none

module spd_mul (
  input  wire logic                           clk_i,
  input  wire logic                           en_i,
  input  wire logic [spd_pkg::LEN_BITS-1:0]   op_a_i,
  input  wire logic [spd_pkg::LEN_BITS-1:0]   op_b_i,
  output logic      [spd_pkg::PROD_BITS-1:0]  prod_o
);
  import spd_pkg::*;

  logic [PROD_BITS-1:0] prod_q;

  // Hold the product unless a new pair is issued.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      prod_q <= PROD_BITS'(op_a_i) * PROD_BITS'(op_b_i);
    end
  end

  assign prod_o = prod_q;

endmodule

`default_nettype wire

>>> design/spd_checker.sv
// Port-level checks for the stroke point decimator, bound to the top level.
// Depends on spd_pkg and stroke_point_decimator.
`default_nettype none

module spd_props (
  input wire logic              clk_i,
  input wire logic              rst_ni,
  input wire logic              in_valid_i,
  input wire logic              in_ready_o,
  input wire logic              out_valid_o,
  input wire logic              out_ready_i,
  input wire spd_pkg::spd_out_t out_o
);
  import spd_pkg::*;

  // A result beat holds until taken.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_o))
    else $error("result beat changed while stalled");

  // One point at a time: ready drops right after an accepted beat.
  a_one_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("input accepted while previous point still at work");

  // An end marker carries no coordinates and closes both stroke and run.
  a_marker: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_o.point_valid |->
      out_o.stroke_end && out_o.run_last && (out_o.out_x == '0) && (out_o.out_y == '0))
    else $error("malformed end marker");

  // The final beat of a stroke is always the last beat of its run.
  a_end_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_o.stroke_end |-> out_o.run_last)
    else $error("stroke end without run end");

endmodule

bind stroke_point_decimator spd_props u_spd_props (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_o       (out_o)
);

`default_nettype wire
